/* src/catrom_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catrom_pkg
// Shared types and constants of the closed-loop Catmull-Rom evaluator.
// ----------------------------------------------------------------------------
package catrom_pkg;

  // Width of the point count register and of every loop index.
  localparam int unsigned IDX_W = 7;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned POINT_W = 3 * COORD_W;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 8;
  localparam logic [IDX_W-1:0] PC_RESET = 7'd4;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  // One input word.
  typedef struct packed {
    op_e                      op;
    logic [5:0]               point_index;
    logic signed [31:0]       point_x;
    logic signed [31:0]       point_y;
    logic signed [31:0]       point_z;
    logic [FRAC_W-1:0]        global_t;
  } in_t;

  // One result word.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tan_x;
    logic signed [31:0] tan_y;
    logic signed [31:0] tan_z;
  } out_t;

  // Classified command between the front and the back.
  // For a write, idx[0] carries the slot and wr_ok tells whether it exists.
  typedef struct packed {
    op_e                         op;
    logic                        wr_ok;
    logic [3:0][IDX_W-1:0]       idx;
    logic [FRAC_W-1:0]           frac;
    logic [POINT_W-1:0]          point;
  } cmd_t;

  // Handshake between the command queue and the back.
  typedef struct packed {
    logic valid;
    logic pop;
  } cmd_hs_t;

endpackage

/* src/catrom_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catrom_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module catrom_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/catrom_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catrom_fifo
// Small register FIFO with a fill count; depth must be a power of two.
// ----------------------------------------------------------------------------
module catrom_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  // Pointer and count update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* src/catrom_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catrom_front
// Accepts input words, scales the loop parameter, derives the four wrapped
// neighbor indices and queues the classified command for the back.
// ----------------------------------------------------------------------------
module catrom_front
  import catrom_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] point_count_i,
  input  logic             push_i,
  input  in_t              in_word_i,
  output logic             full_o,
  input  logic             cmd_pop_i,
  output cmd_t             cmd_o,
  output logic             cmd_valid_o
);

  logic [IDX_W-1:0]        n_eff, seg, nxt2;
  logic [IDX_W+FRAC_W-1:0] scaled;
  cmd_t                    cmd;
  logic                    q_empty;
  logic [$clog2(CMD_DEPTH+1)-1:0] q_count;

  // Clamp the point count and split the scaled parameter.
  always_comb begin
    n_eff = (point_count_i == '0) ? IDX_W'(1) : point_count_i;
    if (32'(n_eff) > MAX_POINTS) begin
      n_eff = IDX_W'(MAX_POINTS);
    end
    scaled = (IDX_W+FRAC_W)'(n_eff) * (IDX_W+FRAC_W)'(in_word_i.global_t);
    seg    = scaled[IDX_W+FRAC_W-1:FRAC_W];
    nxt2   = (IDX_W'(seg + IDX_W'(1)) == n_eff) ? '0 : IDX_W'(seg + IDX_W'(1));
  end

  // Build the command word.
  always_comb begin
    cmd.op    = in_word_i.op;
    cmd.frac  = scaled[FRAC_W-1:0];
    cmd.point = {in_word_i.point_x, in_word_i.point_y, in_word_i.point_z};
    cmd.wr_ok = (32'(in_word_i.point_index) < MAX_POINTS);
    if (in_word_i.op == OP_WRITE) begin
      cmd.idx    = '0;
      cmd.idx[0] = IDX_W'(in_word_i.point_index);
    end else begin
      cmd.idx[0] = (seg == '0) ? n_eff - IDX_W'(1) : seg - IDX_W'(1);
      cmd.idx[1] = seg;
      cmd.idx[2] = nxt2;
      cmd.idx[3] = (IDX_W'(nxt2 + IDX_W'(1)) == n_eff) ? '0 : IDX_W'(nxt2 + IDX_W'(1));
    end
  end

  // Command queue between front and back.
  catrom_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  assign cmd_valid_o = !q_empty && (q_count != '0);

endmodule

/* src/catrom_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catrom_back
// Executes queued commands: point writes go to the point tables, evaluations
// run through a five-stage weight and blend pipeline into the result queue.
// ----------------------------------------------------------------------------
module catrom_back
  import catrom_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  logic    cmd_valid_i,
  output cmd_hs_t cmd_hs_o,
  output out_t    out_word_o,
  output logic    empty_o,
  input  logic    pop_i
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

  logic              issue, issue_eval, issue_wr, room;
  logic [CW-1:0]     out_cnt;
  logic [2:0]        inflight;
  logic              out_full;
  logic [POINT_W-1:0] rdata [4];

  // Stage registers.
  logic                     v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [FRAC_W-1:0]        a1_q, a2a_q;
  logic [31:0]              sq1_q, sq2_q;
  logic [47:0]              cu2_q;
  logic [POINT_W-1:0]       pts2_q [4];
  logic [POINT_W-1:0]       pts3_q [4];
  logic signed [31:0]       w3_q [4];
  logic signed [31:0]       d3_q [4];
  logic signed [63:0]       prod4_q [6][4];
  logic signed [64:0]       pair5_q [6][2];

  logic signed [53:0]       wa, wsq, wcu;
  logic signed [53:0]       wr [4];
  logic signed [39:0]       da, dsq;
  logic signed [39:0]       dr [4];
  logic signed [31:0]       w_d [4];
  logic signed [31:0]       d_d [4];
  logic signed [31:0]       coord [3][4];
  logic signed [63:0]       prod_d [6][4];
  logic signed [65:0]       tot [6];
  logic signed [36:0]       rnd [6];
  logic signed [31:0]       res [6];
  out_t                     res_word;

  // Writes issue at once; evals wait for room for all results in flight.
  always_comb begin
    inflight = 3'(v1_q) + 3'(v2_q) + 3'(v3_q) + 3'(v4_q) + 3'(v5_q);
    room     = ({1'b0, out_cnt} + (CW+1)'(inflight)) < (CW+1)'(OUT_DEPTH);
    issue    = cmd_valid_i && ((cmd_i.op == OP_WRITE) || room);
    issue_eval = issue && (cmd_i.op == OP_EVAL);
    issue_wr   = issue && (cmd_i.op == OP_WRITE) && cmd_i.wr_ok;
    cmd_hs_o.valid = cmd_valid_i;
    cmd_hs_o.pop   = issue;
  end

  // Four copies of the point table, one read port per neighbor.
  for (genvar k = 0; k < 4; k++) begin : g_tab
    catrom_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS)
    ) u_tab (
      .clk_i   (clk_i),
      .we_i    (issue_wr),
      .waddr_i (AW'(cmd_i.idx[0])),
      .wdata_i (cmd_i.point),
      .raddr_i (AW'(cmd_i.idx[k])),
      .rdata_o (rdata[k])
    );
  end

  // Valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= issue_eval;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Basis weights from the fraction, then rounded to Q.29.
  always_comb begin
    wa  = 54'(a2a_q);
    wsq = 54'(sq2_q);
    wcu = 54'(cu2_q);
    wr[0] = -wcu + (wsq <<< 17) - (wa <<< 32);
    wr[1] = 54'sd3 * wcu - 54'sd5 * (wsq <<< 16) + (54'sd1 <<< 49);
    wr[2] = -(54'sd3 * wcu) + 54'sd4 * (wsq <<< 16) + (wa <<< 32);
    wr[3] = wcu - (wsq <<< 16);
    da  = 40'(a2a_q);
    dsq = 40'(sq2_q);
    dr[0] = -(40'sd3 * dsq) + 40'sd4 * (da <<< 16) - (40'sd1 <<< 32);
    dr[1] = 40'sd9 * dsq - 40'sd10 * (da <<< 16);
    dr[2] = -(40'sd9 * dsq) + 40'sd8 * (da <<< 16) + (40'sd1 <<< 32);
    dr[3] = 40'sd3 * dsq - 40'sd2 * (da <<< 16);
    for (int k = 0; k < 4; k++) begin
      w_d[k] = 32'((wr[k] + (54'sd1 <<< 19)) >>> 20);
      d_d[k] = 32'((dr[k] + 40'sd8) >>> 4);
    end
  end

  // Products of weights and coordinates.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      coord[0][k] = pts3_q[k][95:64];
      coord[1][k] = pts3_q[k][63:32];
      coord[2][k] = pts3_q[k][31:0];
    end
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        prod_d[c][k]   = 64'(w3_q[k]) * 64'(coord[c][k]);
        prod_d[c+3][k] = 64'(d3_q[k]) * 64'(coord[c][k]);
      end
    end
  end

  // Final sum, round half up to Q16.16 and saturate.
  always_comb begin
    for (int o = 0; o < 6; o++) begin
      tot[o] = 66'(pair5_q[o][0]) + 66'(pair5_q[o][1]) + (66'sd1 <<< 28);
      rnd[o] = 37'(tot[o] >>> 29);
      if (rnd[o] > 37'sd2147483647) begin
        res[o] = 32'sh7fffffff;
      end else if (rnd[o] < -37'sd2147483648) begin
        res[o] = 32'sh80000000;
      end else begin
        res[o] = 32'(rnd[o]);
      end
    end
    res_word.pos_x = res[0];
    res_word.pos_y = res[1];
    res_word.pos_z = res[2];
    res_word.tan_x = res[3];
    res_word.tan_y = res[4];
    res_word.tan_z = res[5];
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    a1_q   <= cmd_i.frac;
    sq1_q  <= 32'(cmd_i.frac) * 32'(cmd_i.frac);
    a2a_q  <= a1_q;
    sq2_q  <= sq1_q;
    cu2_q  <= 48'(sq1_q) * 48'(a1_q);
    for (int k = 0; k < 4; k++) begin
      pts2_q[k] <= rdata[k];
      pts3_q[k] <= pts2_q[k];
      w3_q[k]   <= w_d[k];
      d3_q[k]   <= d_d[k];
    end
    prod4_q <= prod_d;
    for (int o = 0; o < 6; o++) begin
      pair5_q[o][0] <= 65'(prod4_q[o][0]) + 65'(prod4_q[o][1]);
      pair5_q[o][1] <= 65'(prod4_q[o][2]) + 65'(prod4_q[o][3]);
    end
  end

  // Result queue.
  catrom_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (v5_q),
    .data_i  (res_word),
    .full_o  (out_full),
    .pop_i   (pop_i && !out_full || pop_i),
    .data_o  (out_word_o),
    .empty_o (empty_o),
    .count_o (out_cnt)
  );

endmodule

/* src/catmull_rom_loop_evaluator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_loop_evaluator
// Closed-loop Catmull-Rom spline evaluator: position and tangent per word.
//
//   channel   direction  handshake          payload
//   input     in         push / full        in_word_i  (in_t)
//   result    out        empty / pop        out_word_o (out_t)
//   config    in         cfg_we_i           cfg_wdata_i (point count)
//
// One word is accepted per cycle while the command queue is not full; an
// evaluation leaving the queue runs through the table read, two fraction
// multiplies, the weight rounding and the blend multiply and adder tree.
// Write words produce no result and complete when they leave the queue.
// Reset clears the queues and sets the point count to four; the point
// tables are not cleared. An evaluation waits until the result queue has room.
// ----------------------------------------------------------------------------
module catmull_rom_loop_evaluator
  import catrom_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  in_t              in_word_i,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output out_t             out_word_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_wdata_i
);

  logic [IDX_W-1:0] point_count_q;
  cmd_t             cmd;
  logic             cmd_valid;
  cmd_hs_t          cmd_hs;

  // Point count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= PC_RESET;
    end else if (cfg_we_i) begin
      point_count_q <= cfg_wdata_i;
    end
  end

  catrom_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .point_count_i (point_count_q),
    .push_i        (push),
    .in_word_i     (in_word_i),
    .full_o        (full),
    .cmd_pop_i     (cmd_hs.pop),
    .cmd_o         (cmd),
    .cmd_valid_o   (cmd_valid)
  );

  catrom_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_hs_o    (cmd_hs),
    .out_word_o  (out_word_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  // The back only takes commands that exist.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_hs.pop |-> cmd_hs.valid)
    else $error("command popped from empty queue");

  // A waiting result stays until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result lost without pop");

  // A full command queue always offers a command to the back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> cmd_valid)
    else $error("full command queue shows no command");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the closed-loop Catmull-Rom evaluator. It fills the
// control point table, evaluates at the reset point count, then sweeps several point
// counts. Each sweep phase mixes point writes with curve evaluations, with random gaps
// on the push side and random stalls on the pop side, but for a calm last part. Every
// result is compared field by field with a position and tangent computed in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import catrom_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE = 24;

  // Holds the point table and the point count, and predicts each result word.
  class spline_scoreboard;
    logic signed [31:0] tab_x[64];
    logic signed [31:0] tab_y[64];
    logic signed [31:0] tab_z[64];
    logic [IDX_W-1:0]   count;
    out_t               pending_q[$];
    int unsigned        errors;

    function new();
      count = PC_RESET;
      errors = 0;
    endfunction

    // Round half up of v / 2^s.
    function longint rnd(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function logic signed [31:0] mix(longint wt[4], logic signed [31:0] c[4]);
      longint acc;
      acc = 0;
      for (int k = 0; k < 4; k++) acc += wt[k] * longint'(c[k]);
      acc = rnd(acc, 29);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      return acc[31:0];
    endfunction

    // Notes one accepted input word: a table update or a new expectation.
    function void note_word(in_t w);
      int unsigned n, s, seg;
      int unsigned sel[4];
      longint a, a2, a3;
      longint wp[4], wd[4];
      logic signed [31:0] cx[4], cy[4], cz[4];
      out_t r;
      if (w.op == OP_WRITE) begin
        tab_x[w.point_index] = w.point_x;
        tab_y[w.point_index] = w.point_y;
        tab_z[w.point_index] = w.point_z;
        return;
      end
      n = count;
      if (n == 0) n = 1;
      if (n > 64) n = 64;
      s = n * w.global_t;
      seg = s >> 16;
      a = s & 16'hFFFF;
      a2 = a * a;
      a3 = a2 * a;
      sel[0] = (seg + n - 1) % n;
      for (int k = 1; k < 4; k++) sel[k] = (sel[k-1] + 1) % n;
      wp[0] = -a3 + (a2 <<< 17) - (a <<< 32);
      wp[1] = 3 * a3 - 5 * (a2 <<< 16) + (longint'(1) <<< 49);
      wp[2] = -3 * a3 + 4 * (a2 <<< 16) + (a <<< 32);
      wp[3] = a3 - (a2 <<< 16);
      wd[0] = -3 * a2 + 4 * (a <<< 16) - (longint'(1) <<< 32);
      wd[1] = 9 * a2 - 10 * (a <<< 16);
      wd[2] = -9 * a2 + 8 * (a <<< 16) + (longint'(1) <<< 32);
      wd[3] = 3 * a2 - 2 * (a <<< 16);
      for (int k = 0; k < 4; k++) begin
        wp[k] = rnd(wp[k], 20);
        wd[k] = rnd(wd[k], 4);
        cx[k] = tab_x[sel[k]];
        cy[k] = tab_y[sel[k]];
        cz[k] = tab_z[sel[k]];
      end
      r.pos_x = mix(wp, cx);
      r.pos_y = mix(wp, cy);
      r.pos_z = mix(wp, cz);
      r.tan_x = mix(wd, cx);
      r.tan_y = mix(wd, cy);
      r.tan_z = mix(wd, cz);
      pending_q = {pending_q, r};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h, expected %h", what, got, want);
    endtask

    // Checks one accepted result word against the oldest expectation.
    task check_word(out_t got);
      out_t e;
      if (pending_q.size() == 0) begin
        report("unexpected word, pos_x", got.pos_x, 32'h0);
        return;
      end
      e = pending_q.pop_front();
      if (got.pos_x !== e.pos_x) report("pos_x", got.pos_x, e.pos_x);
      if (got.pos_y !== e.pos_y) report("pos_y", got.pos_y, e.pos_y);
      if (got.pos_z !== e.pos_z) report("pos_z", got.pos_z, e.pos_z);
      if (got.tan_x !== e.tan_x) report("tan_x", got.tan_x, e.tan_x);
      if (got.tan_y !== e.tan_y) report("tan_y", got.tan_y, e.tan_y);
      if (got.tan_z !== e.tan_z) report("tan_z", got.tan_z, e.tan_z);
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  in_t              in_word_i;
  logic             full;
  logic             empty;
  logic             pop;
  out_t             out_word_o;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_wdata_i;

  spline_scoreboard sb = new();
  bit               calm;
  int unsigned      cycles;

  catmull_rom_loop_evaluator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_word_i  (in_word_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit guards against a hung handshake.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Result side: sampled at the edge, before the block updates its outputs.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_word(out_word_o);
  end

  // Pop driver with random stall bursts until the calm part of the run.
  initial begin
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 6) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  function logic signed [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sh0;
      3: return 32'shFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  function logic [15:0] pick_t();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Pushes one word and waits until it is taken, then maybe idles.
  task send(in_t w);
    push <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    sb.note_word(w);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task write_point(int unsigned slot, logic signed [31:0] x, y, z);
    in_t w;
    w = '0;
    w.op = OP_WRITE;
    w.point_index = 6'(slot);
    w.point_x = x;
    w.point_y = y;
    w.point_z = z;
    w.global_t = 16'($urandom);
    send(w);
  endtask

  task eval_at(logic [15:0] t);
    in_t w;
    w = '0;
    w.op = OP_EVAL;
    w.point_index = 6'($urandom);
    w.point_x = $urandom;
    w.point_y = $urandom;
    w.point_z = $urandom;
    w.global_t = t;
    send(w);
  endtask

  // Stops pushing and waits until every expected word is out.
  task drain();
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task set_count(logic [IDX_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.count = v;
  endtask

  task random_items(int unsigned num);
    for (int unsigned i = 0; i < num; i++) begin
      if ($urandom_range(0, 9) < 3)
        write_point($urandom_range(0, 63), pick_coord(), pick_coord(), pick_coord());
      else
        eval_at(pick_t());
    end
  endtask

  logic [IDX_W-1:0] counts[10];

  initial begin
    push <= 1'b0;
    in_word_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    calm = 1'b0;
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every slot so no evaluation reads an unwritten entry.
    write_point(0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0);
    write_point(1, 32'sh80000000, 32'sh7FFFFFFF, 32'shFFFFFFFF);
    write_point(2, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000);
    write_point(3, 32'sh80000000, 32'sh7FFFFFFF, 32'shFFFF0000);
    for (int unsigned k = 4; k < 64; k++)
      write_point(k, pick_coord(), pick_coord(), pick_coord());

    // Directed evaluations at the reset point count.
    eval_at(16'h0000);
    eval_at(16'hFFFF);
    eval_at(16'h8000);
    eval_at(16'h0001);
    eval_at(16'h4000);
    eval_at(16'hC000);
    drain();

    // Point count sweep: zero, one, the maximum, values above it, small and random counts.
    counts = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd65, 7'd2, 7'd3, 7'd4, 7'd0, 7'd0};
    counts[8] = IDX_W'($urandom_range(1, 64));
    counts[9] = IDX_W'($urandom_range(5, 63));
    foreach (counts[p]) begin
      set_count(counts[p]);
      eval_at(16'h0000);
      eval_at(16'hFFFF);
      random_items(40);
      // Hold the sender until the block has emptied, then carry on.
      drain();
      random_items(40);
      drain();
    end

    // Last part without idling on either side.
    calm = 1'b1;
    set_count(7'd64);
    random_items(60);
    drain();

    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/catrom_pkg.sv
src/catrom_ram.sv
src/catrom_fifo.sv
src/catrom_front.sv
src/catrom_back.sv
src/catmull_rom_loop_evaluator.sv
bench/testbench.sv
